// ===== sv/bpa_pkg.sv =====
// Shared types, constants and helpers of the buddy page allocator.
`timescale 1ns / 1ps
package bpa_pkg;

  // Frame store geometry
  localparam int FRAMES = 262144;
  localparam int FW     = 18;   // frame index width
  localparam int CW     = 19;   // frame count width
  localparam int ORDERS = 11;
  localparam int OW     = 4;    // order width

  localparam logic [CW-1:0] FRAME_COUNT_RESET = 19'd245760;
  localparam logic          REG_FRAME_COUNT   = 1'b0;

  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_FREE    = 2'd1,
    REQ_RESERVE = 2'd2,
    REQ_FINAL   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_BLOCK = 2'd1,
    ST_ZERO     = 2'd2
  } status_t;

  // Datapath micro-operations, one per controller state
  typedef enum logic [4:0] {
    OP_IDLE, OP_CLEAR, OP_DISPATCH, OP_AL_CHK, OP_AL_SPLIT, OP_UL_RD, OP_UL_WR,
    OP_PH1, OP_PH2, OP_PT1, OP_PT2, OP_FR_CHK, OP_FR_LOOP, OP_FR_BUD, OP_FR_UL2,
    OP_FR_MRG, OP_RS, OP_FN_P1, OP_FN_A, OP_FN_B, OP_FN_P2RD, OP_FN_P2, OP_FINISH
  } op_t;

  typedef struct packed {
    op_t  op;
    logic accept;
  } cmd_t;

  typedef struct packed {
    req_t typ;
    logic clr_last;
    logic al_fail;
    logic sp_more;
    logic fr_ok;
    logic fl_brk;
    logic fb_brk;
    logic rs_more;
    logic p1_done;
    logic p1_skip;
    logic p2_more;
    logic p2_push;
    logic out_busy;
  } sts_t;

  // Smallest order whose block holds the given page count
  function automatic logic [4:0] want_order(input logic [CW-1:0] pages);
    logic [CW-1:0] m;
    logic [4:0]    w;
    m = pages - 19'd1;
    w = 5'd0;
    for (int k = 0; k < CW; k++) begin
      if (m[k]) w = 5'(k + 1);
    end
    return w;
  endfunction

endpackage

// ===== sv/bpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bpa_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // Write, and read with the new data on an address clash
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (we && waddr == raddr) rdata <= wdata;
    else rdata <= mem[raddr];
  end

endmodule

// ===== sv/bpa_dp.sv =====
// Datapath of the buddy page allocator: frame stores, free lists, result register.
`timescale 1ns / 1ps
module bpa_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  bpa_pkg::cmd_t              cmd,
  output bpa_pkg::sts_t              sts,
  input  logic [bpa_pkg::CW-1:0]     frame_count,
  input  logic [1:0]                 req_type,
  input  logic [bpa_pkg::CW-1:0]     page_count,
  input  logic [bpa_pkg::FW-1:0]     frame_index,
  input  logic [bpa_pkg::CW-1:0]     frame_end,
  input  logic                       rsp_stall,
  output logic                       rsp_valid,
  output logic [1:0]                 status,
  output logic [bpa_pkg::FW-1:0]     alloc_frame,
  output logic [bpa_pkg::OW-1:0]     alloc_order
);

  localparam int FW = bpa_pkg::FW;
  localparam int CW = bpa_pkg::CW;
  localparam int OW = bpa_pkg::OW;
  localparam int NO = bpa_pkg::ORDERS;

  // Transaction registers
  bpa_pkg::req_t typ;
  logic [CW-1:0] pages;
  logic [FW-1:0] idx;
  logic [CW-1:0] fend;
  logic [4:0]    want;
  logic [OW-1:0] cur;
  logic [FW-1:0] bud;
  logic [FW-1:0] nd;
  logic [OW-1:0] no;
  logic [CW-1:0] f;
  logic [OW-1:0] lvl;
  logic          fr1;
  logic [OW-1:0] or1;
  logic [FW-1:0] ph_f;
  logic          ph_ne;
  logic [1:0]    st;
  logic [FW-1:0] rf;
  logic [OW-1:0] ro;
  logic [FW-1:0] clr;

  // Free lists
  logic [FW-1:0] list_first [NO];
  logic [FW-1:0] list_last  [NO];
  logic [NO-1:0] list_ne;

  // Memory ports
  logic [FW-1:0] fo_raddr;
  logic          fr_we, fr_wd, fr_rd;
  logic [FW-1:0] fr_wa;
  logic          od_we;
  logic [FW-1:0] od_wa;
  logic [OW-1:0] od_wd, ord_rd;
  logic          ln_we, lp_we;
  logic [FW-1:0] ln_wa, ln_wd, lp_wa, lp_wd, ln_rd, lp_rd;

  // Derived values
  logic [CW-1:0] lim, rs_end, f2, fb_next;
  logic [NO-1:0] cand;
  logic          found;
  logic [OW-1:0] a_c;
  logic [FW-1:0] bud_fr, bud_al;
  logic          no_ok, ne_sel, hit_f, hit_l, ul_ok, ul_mid, merge, ord_ok;
  logic [FW-1:0] fst_sel, lst_sel;

  assign lim = (frame_count < CW'(bpa_pkg::FRAMES)) ? frame_count : CW'(bpa_pkg::FRAMES);

  // Lowest non-empty list at or above the wanted order
  always_comb begin
    for (int k = 0; k < NO; k++) cand[k] = list_ne[k] && (5'(k) >= want);
    found = |cand;
    a_c   = '0;
    for (int k = NO - 1; k >= 0; k--) begin
      if (cand[k]) a_c = OW'(k);
    end
  end

  assign bud_fr  = idx ^ (FW'(1) << cur);
  assign bud_al  = idx ^ (FW'(1) << (cur - OW'(1)));
  assign rs_end  = (fend < lim) ? fend : lim;
  assign f2      = f + (CW'(1) << lvl);
  assign fb_next = f + (CW'(1) << ({1'b0, lvl} + 5'd1));
  assign ord_ok  = {1'b0, ord_rd} < 5'(NO);
  assign merge   = fr1 && (or1 == lvl) && fr_rd && (ord_rd == lvl);

  // Selected list entry for the current node order
  always_comb begin
    no_ok   = {1'b0, no} < 5'(NO);
    ne_sel  = 1'b0;
    fst_sel = '0;
    lst_sel = '0;
    if (no_ok) begin
      ne_sel  = list_ne[no];
      fst_sel = list_first[no];
      lst_sel = list_last[no];
    end
    ul_ok  = no_ok && ne_sel;
    hit_f  = fst_sel == nd;
    hit_l  = lst_sel == nd;
    ul_mid = ul_ok && !hit_f && !hit_l;
  end

  // Status towards the controller
  always_comb begin
    sts.typ      = typ;
    sts.clr_last = clr == '1;
    sts.al_fail  = (pages == '0) || (want >= 5'(NO)) || !found;
    sts.sp_more  = {1'b0, cur} > want;
    sts.fr_ok    = ({1'b0, idx} < lim) && !fr_rd && ord_ok;
    sts.fl_brk   = ({1'b0, cur} + 5'd1 >= 5'(NO)) || ({1'b0, bud_fr} >= lim);
    sts.fb_brk   = !fr_rd || (ord_rd != cur);
    sts.rs_more  = f < rs_end;
    sts.p1_done  = {1'b0, lvl} + 5'd1 >= 5'(NO);
    sts.p1_skip  = f2 >= lim;
    sts.p2_more  = f < lim;
    sts.p2_push  = fr_rd && ord_ok;
    sts.out_busy = rsp_valid && rsp_stall;
  end

  // Memory port steering
  always_comb begin
    fo_raddr = idx;
    fr_we = 1'b0; fr_wa = idx; fr_wd = 1'b0;
    od_we = 1'b0; od_wa = idx; od_wd = '0;
    ln_we = 1'b0; ln_wa = nd;  ln_wd = '0;
    lp_we = 1'b0; lp_wa = nd;  lp_wd = '0;
    case (cmd.op)
      bpa_pkg::OP_CLEAR: begin
        fr_we = 1'b1; fr_wa = clr; fr_wd = 1'b1;
        od_we = 1'b1; od_wa = clr; od_wd = '0;
      end
      bpa_pkg::OP_AL_SPLIT: begin
        fr_we = 1'b1; od_we = 1'b1;
        if (sts.sp_more) begin
          fr_wa = bud_al; fr_wd = 1'b1;
          od_wa = bud_al; od_wd = cur - OW'(1);
        end else begin
          fr_wa = idx; fr_wd = 1'b0;
          od_wa = idx; od_wd = want[OW-1:0];
        end
      end
      bpa_pkg::OP_FR_CHK: begin
        if (sts.fr_ok) begin
          fr_we = 1'b1; fr_wa = idx; fr_wd = 1'b1;
        end
      end
      bpa_pkg::OP_FR_LOOP: fo_raddr = bud_fr;
      bpa_pkg::OP_FR_MRG: begin
        od_we = 1'b1; od_wa = idx & bud; od_wd = cur + OW'(1);
      end
      bpa_pkg::OP_RS: begin
        if (sts.rs_more) begin
          fr_we = 1'b1; fr_wa = f[FW-1:0]; fr_wd = 1'b0;
        end
      end
      bpa_pkg::OP_FN_P1:   fo_raddr = f[FW-1:0];
      bpa_pkg::OP_FN_A:    fo_raddr = f2[FW-1:0];
      bpa_pkg::OP_FN_B: begin
        if (merge) begin
          od_we = 1'b1; od_wa = f[FW-1:0]; od_wd = lvl + OW'(1);
        end
      end
      bpa_pkg::OP_FN_P2RD: fo_raddr = f[FW-1:0];
      bpa_pkg::OP_UL_WR: begin
        if (ul_mid) begin
          ln_we = 1'b1; ln_wa = lp_rd; ln_wd = ln_rd;
          lp_we = 1'b1; lp_wa = ln_rd; lp_wd = lp_rd;
        end
      end
      bpa_pkg::OP_PH1: begin
        if (no_ok) begin
          lp_we = 1'b1; lp_wa = nd; lp_wd = '0;
          ln_we = 1'b1; ln_wa = nd; ln_wd = ne_sel ? fst_sel : '0;
        end
      end
      bpa_pkg::OP_PH2: begin
        if (ph_ne) begin
          lp_we = 1'b1; lp_wa = ph_f; lp_wd = nd;
        end
      end
      bpa_pkg::OP_PT1: begin
        if (no_ok) begin
          ln_we = 1'b1; ln_wa = nd; ln_wd = '0;
          lp_we = 1'b1; lp_wa = nd; lp_wd = ne_sel ? lst_sel : '0;
        end
      end
      bpa_pkg::OP_PT2: begin
        if (ph_ne) begin
          ln_we = 1'b1; ln_wa = ph_f; ln_wd = nd;
        end
      end
      default: ;
    endcase
  end

  bpa_ram #(.W(1), .D(bpa_pkg::FRAMES)) u_free (
    .clk(clk), .we(fr_we), .waddr(fr_wa), .wdata(fr_wd), .raddr(fo_raddr), .rdata(fr_rd)
  );
  bpa_ram #(.W(OW), .D(bpa_pkg::FRAMES)) u_order (
    .clk(clk), .we(od_we), .waddr(od_wa), .wdata(od_wd), .raddr(fo_raddr), .rdata(ord_rd)
  );
  bpa_ram #(.W(FW), .D(bpa_pkg::FRAMES)) u_next (
    .clk(clk), .we(ln_we), .waddr(ln_wa), .wdata(ln_wd), .raddr(nd), .rdata(ln_rd)
  );
  bpa_ram #(.W(FW), .D(bpa_pkg::FRAMES)) u_prev (
    .clk(clk), .we(lp_we), .waddr(lp_wa), .wdata(lp_wd), .raddr(nd), .rdata(lp_rd)
  );

  // Control registers: clearing sweep, list occupancy, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      clr       <= '0;
      list_ne   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.op == bpa_pkg::OP_CLEAR) clr <= clr + FW'(1);
      if (cmd.op == bpa_pkg::OP_FINISH && !sts.out_busy) rsp_valid <= 1'b1;
      else if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      case (cmd.op)
        bpa_pkg::OP_UL_WR: begin
          if (ul_ok && hit_f && hit_l) list_ne[no] <= 1'b0;
        end
        bpa_pkg::OP_PH1, bpa_pkg::OP_PT1: begin
          if (no_ok) list_ne[no] <= 1'b1;
        end
        bpa_pkg::OP_FN_P1: begin
          if (sts.p1_done) list_ne <= '0;
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      bpa_pkg::OP_IDLE: begin
        if (cmd.accept) begin
          typ   <= bpa_pkg::req_t'(req_type);
          pages <= page_count;
          idx   <= frame_index;
          fend  <= frame_end;
        end
      end
      bpa_pkg::OP_DISPATCH: begin
        st   <= bpa_pkg::ST_OK;
        rf   <= '0;
        ro   <= '0;
        lvl  <= '0;
        want <= bpa_pkg::want_order(pages);
        f    <= (typ == bpa_pkg::REQ_RESERVE) ? {1'b0, idx} : '0;
      end
      bpa_pkg::OP_AL_CHK: begin
        if (pages == '0) st <= bpa_pkg::ST_ZERO;
        else if (sts.al_fail) st <= bpa_pkg::ST_NO_BLOCK;
        else begin
          idx <= list_first[a_c];
          nd  <= list_first[a_c];
          no  <= a_c;
          cur <= a_c;
        end
      end
      bpa_pkg::OP_AL_SPLIT: begin
        if (sts.sp_more) begin
          cur <= cur - OW'(1);
          nd  <= bud_al;
          no  <= cur - OW'(1);
        end else begin
          rf <= idx;
          ro <= want[OW-1:0];
        end
      end
      bpa_pkg::OP_UL_WR: begin
        if (ul_ok && hit_f && !hit_l) list_first[no] <= ln_rd;
        else if (ul_ok && !hit_f && hit_l) list_last[no] <= lp_rd;
      end
      bpa_pkg::OP_PH1: begin
        ph_f  <= fst_sel;
        ph_ne <= ne_sel;
        if (no_ok) begin
          list_first[no] <= nd;
          if (!ne_sel) list_last[no] <= nd;
        end
      end
      bpa_pkg::OP_PT1: begin
        ph_f  <= lst_sel;
        ph_ne <= ne_sel;
        if (no_ok) begin
          list_last[no] <= nd;
          if (!ne_sel) list_first[no] <= nd;
        end
      end
      bpa_pkg::OP_FR_CHK: begin
        if (sts.fr_ok) begin
          cur <= ord_rd;
          nd  <= idx;
          no  <= ord_rd;
        end
      end
      bpa_pkg::OP_FR_LOOP: begin
        bud <= bud_fr;
        if (sts.fl_brk) begin
          rf <= idx;
          ro <= cur;
        end
      end
      bpa_pkg::OP_FR_BUD: begin
        if (sts.fb_brk) begin
          rf <= idx;
          ro <= cur;
        end else begin
          nd <= idx;
          no <= cur;
        end
      end
      bpa_pkg::OP_FR_UL2: begin
        nd <= bud;
        no <= cur;
      end
      bpa_pkg::OP_FR_MRG: begin
        idx <= idx & bud;
        nd  <= idx & bud;
        cur <= cur + OW'(1);
        no  <= cur + OW'(1);
      end
      bpa_pkg::OP_RS: begin
        if (sts.rs_more) f <= f + CW'(1);
      end
      bpa_pkg::OP_FN_P1: begin
        if (sts.p1_done) f <= '0;
        else if (sts.p1_skip) begin
          lvl <= lvl + OW'(1);
          f   <= '0;
        end
      end
      bpa_pkg::OP_FN_A: begin
        fr1 <= fr_rd;
        or1 <= ord_rd;
      end
      bpa_pkg::OP_FN_B: begin
        if (fb_next >= lim) begin
          lvl <= lvl + OW'(1);
          f   <= '0;
        end else f <= fb_next;
      end
      bpa_pkg::OP_FN_P2: begin
        nd <= f[FW-1:0];
        no <= ord_rd;
        f  <= f + (CW'(1) << ord_rd);
      end
      bpa_pkg::OP_FINISH: begin
        if (!sts.out_busy) begin
          status      <= st;
          alloc_frame <= rf;
          alloc_order <= ro;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/bpa_ctrl.sv =====
// Controller state machine of the buddy page allocator.
`timescale 1ns / 1ps
module bpa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  bpa_pkg::sts_t sts,
  output bpa_pkg::cmd_t cmd
);

  typedef enum logic [22:0] {
    S_IDLE     = 23'(1) << 0,
    S_CLEAR    = 23'(1) << 1,
    S_DISPATCH = 23'(1) << 2,
    S_AL_CHK   = 23'(1) << 3,
    S_AL_SPLIT = 23'(1) << 4,
    S_UL_RD    = 23'(1) << 5,
    S_UL_WR    = 23'(1) << 6,
    S_PH1      = 23'(1) << 7,
    S_PH2      = 23'(1) << 8,
    S_PT1      = 23'(1) << 9,
    S_PT2      = 23'(1) << 10,
    S_FR_CHK   = 23'(1) << 11,
    S_FR_LOOP  = 23'(1) << 12,
    S_FR_BUD   = 23'(1) << 13,
    S_FR_UL2   = 23'(1) << 14,
    S_FR_MRG   = 23'(1) << 15,
    S_RS       = 23'(1) << 16,
    S_FN_P1    = 23'(1) << 17,
    S_FN_A     = 23'(1) << 18,
    S_FN_B     = 23'(1) << 19,
    S_FN_P2RD  = 23'(1) << 20,
    S_FN_P2    = 23'(1) << 21,
    S_FINISH   = 23'(1) << 22
  } state_t;

  state_t state, state_next, ret, ret_next;

  assign req_stall  = state != S_IDLE;
  assign cmd.accept = (state == S_IDLE) && req_valid;

  // Map each state to its datapath operation
  always_comb begin
    case (state)
      S_IDLE:     cmd.op = bpa_pkg::OP_IDLE;
      S_CLEAR:    cmd.op = bpa_pkg::OP_CLEAR;
      S_DISPATCH: cmd.op = bpa_pkg::OP_DISPATCH;
      S_AL_CHK:   cmd.op = bpa_pkg::OP_AL_CHK;
      S_AL_SPLIT: cmd.op = bpa_pkg::OP_AL_SPLIT;
      S_UL_RD:    cmd.op = bpa_pkg::OP_UL_RD;
      S_UL_WR:    cmd.op = bpa_pkg::OP_UL_WR;
      S_PH1:      cmd.op = bpa_pkg::OP_PH1;
      S_PH2:      cmd.op = bpa_pkg::OP_PH2;
      S_PT1:      cmd.op = bpa_pkg::OP_PT1;
      S_PT2:      cmd.op = bpa_pkg::OP_PT2;
      S_FR_CHK:   cmd.op = bpa_pkg::OP_FR_CHK;
      S_FR_LOOP:  cmd.op = bpa_pkg::OP_FR_LOOP;
      S_FR_BUD:   cmd.op = bpa_pkg::OP_FR_BUD;
      S_FR_UL2:   cmd.op = bpa_pkg::OP_FR_UL2;
      S_FR_MRG:   cmd.op = bpa_pkg::OP_FR_MRG;
      S_RS:       cmd.op = bpa_pkg::OP_RS;
      S_FN_P1:    cmd.op = bpa_pkg::OP_FN_P1;
      S_FN_A:     cmd.op = bpa_pkg::OP_FN_A;
      S_FN_B:     cmd.op = bpa_pkg::OP_FN_B;
      S_FN_P2RD:  cmd.op = bpa_pkg::OP_FN_P2RD;
      S_FN_P2:    cmd.op = bpa_pkg::OP_FN_P2;
      S_FINISH:   cmd.op = bpa_pkg::OP_FINISH;
      default:    cmd.op = bpa_pkg::OP_IDLE;
    endcase
  end

  // Sequence the request; list helpers return through ret
  always_comb begin
    state_next = state;
    ret_next   = ret;
    case (state)
      S_CLEAR:    if (sts.clr_last) state_next = S_IDLE;
      S_IDLE:     if (req_valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        case (sts.typ)
          bpa_pkg::REQ_ALLOC:   state_next = S_AL_CHK;
          bpa_pkg::REQ_FREE:    state_next = S_FR_CHK;
          bpa_pkg::REQ_RESERVE: state_next = S_RS;
          default:              state_next = S_FN_P1;
        endcase
      end
      S_AL_CHK: begin
        if (sts.al_fail) state_next = S_FINISH;
        else begin
          ret_next   = S_AL_SPLIT;
          state_next = S_UL_RD;
        end
      end
      S_AL_SPLIT: begin
        if (sts.sp_more) begin
          ret_next   = S_AL_SPLIT;
          state_next = S_PH1;
        end else state_next = S_FINISH;
      end
      S_UL_RD: state_next = S_UL_WR;
      S_UL_WR: state_next = ret;
      S_PH1:   state_next = S_PH2;
      S_PH2:   state_next = ret;
      S_PT1:   state_next = S_PT2;
      S_PT2:   state_next = ret;
      S_FR_CHK: begin
        if (sts.fr_ok) begin
          ret_next   = S_FR_LOOP;
          state_next = S_PH1;
        end else state_next = S_FINISH;
      end
      S_FR_LOOP: state_next = sts.fl_brk ? S_FINISH : S_FR_BUD;
      S_FR_BUD: begin
        if (sts.fb_brk) state_next = S_FINISH;
        else begin
          ret_next   = S_FR_UL2;
          state_next = S_UL_RD;
        end
      end
      S_FR_UL2: begin
        ret_next   = S_FR_MRG;
        state_next = S_UL_RD;
      end
      S_FR_MRG: begin
        ret_next   = S_FR_LOOP;
        state_next = S_PH1;
      end
      S_RS: if (!sts.rs_more) state_next = S_FINISH;
      S_FN_P1: begin
        if (sts.p1_done) state_next = S_FN_P2RD;
        else if (!sts.p1_skip) state_next = S_FN_A;
      end
      S_FN_A:    state_next = S_FN_B;
      S_FN_B:    state_next = S_FN_P1;
      S_FN_P2RD: state_next = sts.p2_more ? S_FN_P2 : S_FINISH;
      S_FN_P2: begin
        if (sts.p2_push) begin
          ret_next   = S_FN_P2RD;
          state_next = S_PT1;
        end else state_next = S_FN_P2RD;
      end
      S_FINISH: if (!sts.out_busy) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ret   <= S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

endmodule

// ===== sv/buddy_page_allocator.sv =====
// Top level of the buddy page allocator: register port, controller and datapath.
`timescale 1ns / 1ps
// Buddy allocator over 262144 page frames, 11 orders. One request in, one
// transaction out. After reset the block sweeps the frame order and free
// stores, one frame per cycle, over every frame before it takes a request.
// Requests run one at a time through a sequencer over frame and link memories
// with one write and one read port each: allocate splits one order at a time,
// free merges with the buddy one order at a time, reserve takes each frame in
// range in turn, finalize merges free buddy pairs per order and then builds the
// lists. The result sits in an output register, so a stalled result does not
// hold the next request back until that request ends.
module buddy_page_allocator (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  logic [1:0]             req_type,
  input  logic [18:0]            page_count,
  input  logic [17:0]            frame_index,
  input  logic [18:0]            frame_end,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output logic [1:0]             status,
  output logic [17:0]            alloc_frame,
  output logic [3:0]             alloc_order
);

  logic [bpa_pkg::CW-1:0] frame_count;
  bpa_pkg::cmd_t          cmd;
  bpa_pkg::sts_t          sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == bpa_pkg::REG_FRAME_COUNT) ? {13'd0, frame_count} : 32'd0;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) frame_count <= bpa_pkg::FRAME_COUNT_RESET;
    else if (psel && penable && pwrite && pready && paddr[2] == bpa_pkg::REG_FRAME_COUNT)
      frame_count <= pwdata[bpa_pkg::CW-1:0];
  end

  bpa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall),
    .sts(sts), .cmd(cmd)
  );

  bpa_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .frame_count(frame_count),
    .req_type(req_type), .page_count(page_count), .frame_index(frame_index),
    .frame_end(frame_end), .rsp_stall(rsp_stall), .rsp_valid(rsp_valid),
    .status(status), .alloc_frame(alloc_frame), .alloc_order(alloc_order)
  );

`ifndef SYNTHESIS
  // One request in flight: no acceptance right after another
  a_single: assert property (@(posedge clk) disable iff (rst) cmd.accept |=> !cmd.accept)
    else $error("request accepted while one is in flight");

  // A result appears only from the finishing step
  a_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(cmd.op == bpa_pkg::OP_FINISH))
    else $error("result raised outside the finishing step");

  // No request is taken during the clearing sweep
  a_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.op == bpa_pkg::OP_CLEAR |-> !cmd.accept)
    else $error("request accepted during clearing sweep");

  // Status codes stay within the defined set
  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status == bpa_pkg::ST_OK || status == bpa_pkg::ST_NO_BLOCK ||
                   status == bpa_pkg::ST_ZERO))
    else $error("undefined status code");
`endif

endmodule
